@@ rtl/core/ale_pkg.sv @@
// Shared types and codes for the array list engine.
package ale_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_MODIFY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int IDX_W  = 4;
    localparam int LEN_W  = 5;

    typedef struct packed {
        logic [1:0]               operation;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] new_value;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] found_index;
        logic [LEN_W-1:0] list_length;
    } t_out;

endpackage

@@ rtl/core/ale_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/array_list_engine.sv @@
// Top level of the array list engine: ordered list of 32-bit words in a RAM.
//
// An ordered list of up to CAPACITY signed 32-bit words, kept in one RAM with
// a registered read. Each input beat carries one request (insert at
// a position, delete at a position, search by value, modify the first match)
// and yields exactly one output beat with status, match index and the list
// length after the request. One request is in work at a time. Insert and
// delete move entries one per cycle through the RAM (read one entry, write it
// to its neighbor the next cycle, overlapped); search and modify read one
// entry per cycle and compare the registered word. A rejected request (bad
// position, full list, empty search) goes straight to the result with no
// walk. A finished result sits in an output register, so a new beat is taken
// while the previous result is still stalled. No clearing pass after reset:
// only entries below the length are ever read, and those are always written.
module array_list_engine
    import ale_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // RAM address
    localparam int CW = $clog2(CAPACITY + 1);                   // length count
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;        // compare width

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHUP = 3'd1;   // insert: move entries up
    localparam logic [2:0] S_SHDN = 3'd2;   // delete: move entries down
    localparam logic [2:0] S_SCAN = 3'd3;   // search / modify walk
    localparam logic [2:0] S_DONE = 3'd4;   // hand result to output register

    logic [2:0]        r_state;
    logic [CW-1:0]     r_cnt;
    logic [1:0]        r_op;
    logic [AW-1:0]     r_pos;
    logic [WORD_W-1:0] r_val;
    logic [WORD_W-1:0] r_nval;
    logic [AW-1:0]     r_ptr;     // next RAM read address
    logic [AW-1:0]     r_last;    // address read last cycle
    logic              r_more;    // reads still to issue
    logic              r_pend;    // read data arriving this cycle
    t_out              r_res;
    t_out              r_out;
    logic              r_out_valid;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              w_hit;

    logic [EW-1:0]     w_pos_x;
    logic [EW-1:0]     w_cnt_x;
    logic [EW-1:0]     w_cap_x;
    logic [EW-1:0]     w_ptr_inc_x;

    assign w_pos_x     = EW'(i_in_data.position);
    assign w_cnt_x     = EW'(r_cnt);
    assign w_cap_x     = EW'(CAPACITY);
    assign w_ptr_inc_x = EW'(r_ptr) + EW'(1);

    // first match: compare the word read last cycle
    assign w_hit = (r_state == S_SCAN) && r_pend && (rd_data == r_val);

    ale_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // RAM port control. Read and write in one cycle always hit different
    // entries: the write trails the read by one step of the walk.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ptr;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_val;
        unique case (r_state)
            S_SHUP: begin
                rd_en = r_more;
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_last + AW'(1);
                    wr_data = rd_data;
                end else if (!r_more) begin
                    // gap is open: drop the new word in
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_val;
                end
            end
            S_SHDN: begin
                rd_en = r_more;
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_last - AW'(1);
                    wr_data = rd_data;
                end
            end
            S_SCAN: begin
                rd_en = r_more;
                if (w_hit && (r_op == OP_MODIFY)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_last;
                    wr_data = r_nval;
                end
            end
            S_IDLE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_more      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // DONE reloads the output register on its own edge
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op              <= i_in_data.operation;
                        r_pos             <= AW'(i_in_data.position);
                        r_val             <= i_in_data.value;
                        r_nval            <= i_in_data.new_value;
                        r_pend            <= 1'b0;
                        r_res.found_index <= '0;
                        r_res.list_length <= LEN_W'(r_cnt);
                        unique case (i_in_data.operation)
                            OP_INSERT: begin
                                if (w_pos_x > w_cnt_x) begin
                                    r_res.status <= ST_BAD_POS;
                                    r_state      <= S_DONE;
                                end else if (w_cnt_x >= w_cap_x) begin
                                    r_res.status <= ST_FULL;
                                    r_state      <= S_DONE;
                                end else begin
                                    // top entry first; nothing to move at the end
                                    r_res.status <= ST_OK;
                                    r_ptr        <= AW'(r_cnt - CW'(1));
                                    r_more       <= (w_pos_x != w_cnt_x);
                                    r_state      <= S_SHUP;
                                end
                            end
                            OP_DELETE: begin
                                if (w_pos_x >= w_cnt_x) begin
                                    r_res.status <= ST_BAD_POS;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res.status <= ST_OK;
                                    r_ptr        <= AW'(w_pos_x + EW'(1));
                                    r_more       <= ((w_pos_x + EW'(1)) < w_cnt_x);
                                    r_state      <= S_SHDN;
                                end
                            end
                            OP_SEARCH, OP_MODIFY: begin
                                if (r_cnt == '0) begin
                                    r_res.status <= ST_NOT_FOUND;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res.status <= ST_OK;
                                    r_ptr        <= '0;
                                    r_more       <= 1'b1;
                                    r_state      <= S_SCAN;
                                end
                            end
                            default: begin
                                r_res.status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SHUP: begin
                    if (r_more) begin
                        r_last <= r_ptr;
                        r_ptr  <= r_ptr - AW'(1);
                        r_more <= (r_ptr != r_pos);
                    end
                    r_pend <= r_more;
                    if (!r_more && !r_pend) begin
                        r_cnt             <= r_cnt + CW'(1);
                        r_res.list_length <= LEN_W'(r_cnt + CW'(1));
                        r_state           <= S_DONE;
                    end
                end
                S_SHDN: begin
                    if (r_more) begin
                        r_last <= r_ptr;
                        r_ptr  <= r_ptr + AW'(1);
                        r_more <= (w_ptr_inc_x < w_cnt_x);
                    end
                    r_pend <= r_more;
                    if (!r_more && !r_pend) begin
                        r_cnt             <= r_cnt - CW'(1);
                        r_res.list_length <= LEN_W'(r_cnt - CW'(1));
                        r_state           <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        // stray read still in flight is simply dropped
                        r_res.found_index <= IDX_W'(r_last);
                        r_more            <= 1'b0;
                        r_pend            <= 1'b0;
                        r_state           <= S_DONE;
                    end else begin
                        if (r_more) begin
                            r_last <= r_ptr;
                            r_ptr  <= r_ptr + AW'(1);
                            r_more <= (w_ptr_inc_x < w_cnt_x);
                        end
                        r_pend <= r_more;
                        if (!r_more && !r_pend) begin
                            r_res.status <= ST_NOT_FOUND;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/ale_checker.sv @@
// Port-level checker for the array list engine, with its bind.
module ale_checker
    import ale_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed under stall");

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a request is in work");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_NOT_FOUND) |->
        (o_out_data.found_index == '0))
        else $error("miss reported with nonzero index");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL) |->
        (o_out_data.list_length == LEN_W'(CAPACITY)))
        else $error("full status without full length");

    a_length_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 31) || (int'(o_out_data.list_length) <= CAPACITY))
        else $error("length beyond capacity");

endmodule

bind array_list_engine ale_checker #(.CAPACITY(CAPACITY)) u_ale_checker (.*);
